>>> rtl/jkc_pkg.sv
// ----------------------------------------------------------------------------
// jkc_pkg
// Shared types and constants for the joystick key classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package jkc_pkg;

    localparam int JKC_SAMPLE_BITS = 12;
    localparam int JKC_TIME_BITS   = 32;

    // configuration register widths
    localparam int CFG_CENTER_W   = 12;
    localparam int CFG_DEADZONE_W = 11;
    localparam int CFG_MS_W       = 16;
    localparam int CFG_DATA_W     = 16;
    localparam int CFG_INDEX_W    = 2;

    // configuration reset values
    localparam logic [CFG_CENTER_W-1:0]   CFG_CENTER_RST   = 12'd2048;
    localparam logic [CFG_DEADZONE_W-1:0] CFG_DEADZONE_RST = 11'd200;
    localparam logic [CFG_MS_W-1:0]       CFG_DEBOUNCE_RST = 16'd30;
    localparam logic [CFG_MS_W-1:0]       CFG_LONG_RST     = 16'd500;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CENTER   = 2'd0,
        REG_DEADZONE = 2'd1,
        REG_DEBOUNCE = 2'd2,
        REG_LONG     = 2'd3
    } t_cfg_reg;

    typedef enum logic [2:0] {
        KEY_NONE  = 3'd0,
        KEY_RIGHT = 3'd1,
        KEY_LEFT  = 3'd2,
        KEY_NEXT  = 3'd3,
        KEY_PREV  = 3'd4,
        KEY_ENTER = 3'd5,
        KEY_ESC   = 3'd6
    } t_key;

    typedef enum logic [1:0] {
        BTN_NONE  = 2'd0,
        BTN_SHORT = 2'd1,
        BTN_LONG  = 2'd2
    } t_btn_ev;

    typedef struct packed {
        logic [CFG_CENTER_W-1:0]   center;
        logic [CFG_DEADZONE_W-1:0] deadzone;
        logic [CFG_MS_W-1:0]       debounce_ms;
        logic [CFG_MS_W-1:0]       long_ms;
    } t_cfg;

endpackage

`default_nettype wire

>>> rtl/jkc_dir.sv
// ----------------------------------------------------------------------------
// jkc_dir
// Winner-take-all joystick direction with deadzone; ties go to vertical.
// ----------------------------------------------------------------------------
`default_nettype none

module jkc_dir import jkc_pkg::*; #(
    parameter int SAMPLE_BITS = JKC_SAMPLE_BITS
) (
    input  wire logic [SAMPLE_BITS-1:0]    i_x,
    input  wire logic [SAMPLE_BITS-1:0]    i_y,
    input  wire logic [CFG_CENTER_W-1:0]   i_center,
    input  wire logic [CFG_DEADZONE_W-1:0] i_deadzone,
    output t_key                           o_key
);

    localparam int DW = ((SAMPLE_BITS > CFG_CENTER_W) ? SAMPLE_BITS : CFG_CENTER_W) + 1;

    logic signed [DW-1:0] dx, dy;
    logic        [DW-1:0] ax, ay, dz;

    always_comb begin
        dx = $signed({{(DW-SAMPLE_BITS){1'b0}}, i_x}) -
             $signed({{(DW-CFG_CENTER_W){1'b0}}, i_center});
        dy = $signed({{(DW-SAMPLE_BITS){1'b0}}, i_y}) -
             $signed({{(DW-CFG_CENTER_W){1'b0}}, i_center});
        ax = dx[DW-1] ? DW'(-dx) : DW'(dx);
        ay = dy[DW-1] ? DW'(-dy) : DW'(dy);
        dz = {{(DW-CFG_DEADZONE_W){1'b0}}, i_deadzone};

        o_key = KEY_NONE;
        if (ax > ay) begin
            if (ax > dz) o_key = dx[DW-1] ? KEY_LEFT : KEY_RIGHT;
        end else begin
            if (ay > dz) o_key = dy[DW-1] ? KEY_PREV : KEY_NEXT;
        end
    end

endmodule

`default_nettype wire

>>> rtl/jkc_button.sv
// ----------------------------------------------------------------------------
// jkc_button
// Button debounce and short/long press classification, one poll per step.
// ----------------------------------------------------------------------------
`default_nettype none

module jkc_button import jkc_pkg::*; #(
    parameter int TIME_BITS = JKC_TIME_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_step,
    input  wire logic                 i_level,
    input  wire logic [TIME_BITS-1:0] i_now,
    input  wire logic [CFG_MS_W-1:0]  i_debounce_ms,
    input  wire logic [CFG_MS_W-1:0]  i_long_ms,
    output t_btn_ev                   o_event
);

    logic                 r_deb, r_last_raw, r_short, r_long;
    logic [TIME_BITS-1:0] r_last_change, r_press_start;

    logic                 raw_chg, accept, press, deb_new, long_new;
    logic [TIME_BITS-1:0] since_change, held;

    always_comb begin
        raw_chg      = i_level != r_last_raw;
        since_change = i_now - r_last_change;
        // a raw change this poll leaves zero elapsed time, never accepted
        accept  = !raw_chg && (since_change > TIME_BITS'(i_debounce_ms)) &&
                  (i_level != r_deb);
        press   = accept && !i_level;
        deb_new = accept ? i_level : r_deb;
        long_new = press ? 1'b0 : r_long;
        held    = press ? '0 : (i_now - r_press_start);

        o_event = BTN_NONE;
        if (accept && i_level && !r_long && !r_short) begin
            o_event = BTN_SHORT;
        end else if (!deb_new && !long_new && (held >= TIME_BITS'(i_long_ms))) begin
            o_event = BTN_LONG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deb         <= 1'b1;
            r_last_raw    <= 1'b1;
            r_last_change <= '0;
            r_press_start <= '0;
            r_short       <= 1'b0;
            r_long        <= 1'b0;
        end else if (i_step) begin
            r_last_raw <= i_level;
            if (raw_chg) r_last_change <= i_now;
            if (accept)  r_deb         <= i_level;
            if (press) begin
                // a zero hold time fires the long press on the press itself
                r_press_start <= i_now;
                r_short       <= 1'b0;
                r_long        <= (o_event == BTN_LONG);
            end else begin
                if (o_event == BTN_SHORT) r_short <= 1'b1;
                if (o_event == BTN_LONG)  r_long  <= 1'b1;
            end
        end
    end

    // short fires only on release, long only while held: never both flags
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_short && r_long))
        else $error("short and long flags both set");

    a_short_on_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_event == BTN_SHORT) |-> (i_level && !r_deb))
        else $error("short press without release edge");

    a_long_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_event == BTN_LONG) |=> (r_long && !r_deb))
        else $error("long press not latched");

endmodule

`default_nettype wire

>>> rtl/joystick_key_classifier.sv
// ----------------------------------------------------------------------------
// joystick_key_classifier
// Polled joystick direction plus debounced button, one key result per poll.
// ----------------------------------------------------------------------------
//
//  channel   | dir | handshake                        | beat
//  ----------+-----+----------------------------------+---------------------------
//  s_axis    | in  | s_axis_tvalid / s_axis_tready    | x, y, button level, tick
//  m_axis    | out | m_axis_tvalid / m_axis_tready    | pressed, key code
//  cfg write | in  | i_cfg_valid / o_cfg_ready        | register index, data
//
//  Two register stages: an input beat register, then the result register.
//  The direction decode and the button update sit between them, so a result
//  is registered when its beat moves from the input register into the result
//  register, and one beat per cycle flows while m_axis_tready stays high.
//  The input register refills while a result waits, stalling only when both
//  stages are full; button state advances when a beat moves into the result.
//  Synchronous active-low reset clears the stages and restores the register
//  and button defaults; the config port is always ready.
//
`default_nettype none

module joystick_key_classifier import jkc_pkg::*; #(
    parameter int SAMPLE_BITS = JKC_SAMPLE_BITS,
    parameter int TIME_BITS   = JKC_TIME_BITS,
    localparam int IN_W = ((2*SAMPLE_BITS + 1 + TIME_BITS + 7) / 8) * 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // {pad, time_ms, button_level, y_sample, x_sample} from the top bit down: x at bit 0
    input  wire logic [IN_W-1:0]        s_axis_tdata,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // bit 0 pressed, bits 3:1 key_code, bits 7:4 zero
    output logic [7:0]                  m_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int Y_LO = SAMPLE_BITS;
    localparam int L_BIT = 2*SAMPLE_BITS;
    localparam int T_LO = 2*SAMPLE_BITS + 1;

    // configuration registers
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center      <= CFG_CENTER_RST;
            r_cfg.deadzone    <= CFG_DEADZONE_RST;
            r_cfg.debounce_ms <= CFG_DEBOUNCE_RST;
            r_cfg.long_ms     <= CFG_LONG_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_CENTER:   r_cfg.center      <= i_cfg_data[CFG_CENTER_W-1:0];
                REG_DEADZONE: r_cfg.deadzone    <= i_cfg_data[CFG_DEADZONE_W-1:0];
                REG_DEBOUNCE: r_cfg.debounce_ms <= i_cfg_data[CFG_MS_W-1:0];
                REG_LONG:     r_cfg.long_ms     <= i_cfg_data[CFG_MS_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // input beat register
    logic                   r_in_valid;
    logic [SAMPLE_BITS-1:0] r_in_x, r_in_y;
    logic                   r_in_level;
    logic [TIME_BITS-1:0]   r_in_time;

    // result register
    logic r_out_valid;
    t_key r_out_key;

    logic    advance;
    t_key    dir_key, n_key;
    t_btn_ev btn_ev;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_x     <= s_axis_tdata[SAMPLE_BITS-1:0];
            r_in_y     <= s_axis_tdata[Y_LO +: SAMPLE_BITS];
            r_in_level <= s_axis_tdata[L_BIT];
            r_in_time  <= s_axis_tdata[T_LO +: TIME_BITS];
        end
    end

    jkc_dir #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dir (
        .i_x        (r_in_x),
        .i_y        (r_in_y),
        .i_center   (r_cfg.center),
        .i_deadzone (r_cfg.deadzone),
        .o_key      (dir_key)
    );

    jkc_button #(
        .TIME_BITS (TIME_BITS)
    ) u_button (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (advance),
        .i_level       (r_in_level),
        .i_now         (r_in_time),
        .i_debounce_ms (r_cfg.debounce_ms),
        .i_long_ms     (r_cfg.long_ms),
        .o_event       (btn_ev)
    );

    // a button event overrides the direction
    always_comb begin
        case (btn_ev)
            BTN_SHORT: n_key = KEY_ENTER;
            BTN_LONG:  n_key = KEY_ESC;
            default:   n_key = dir_key;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) r_out_key <= n_key;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_key, r_out_key != KEY_NONE};

endmodule

`default_nettype wire
